// ----- src/rdw_pkg.sv -----
package rdw_pkg;

   localparam int SOCKET_ID_WIDTH_DEFAULT = 8;
   localparam int TIME_WIDTH              = 32;
   localparam int CMD_WIDTH               = 3;
   localparam int CSR_DATA_WIDTH          = 32;
   localparam int CSR_ADDR_WIDTH          = 3;

   // word index of a csr access (byte address / 4)
   localparam logic CSR_IDX_DEADLINE = 1'b0;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_ARM    = 3'd0,
      CMD_EXEMPT = 3'd1,
      CMD_DISARM = 3'd2,
      CMD_CHECK  = 3'd3,
      CMD_GUARD  = 3'd4
   } cmd_type;

   // elapsed value reported when nothing can be measured
   localparam logic signed [TIME_WIDTH-1:0] ELAPSED_NONE = '1;

   typedef struct packed {
      logic                          breach;
      logic signed [TIME_WIDTH-1:0]  elapsed_ms;
      logic                          guarded;
   } result_type;

endpackage

// ----- src/rdw_req_if.sv -----
interface rdw_req_if
   import rdw_pkg::*;
#(
   parameter int SOCKET_ID_WIDTH = SOCKET_ID_WIDTH_DEFAULT
) ();
   logic                         valid;
   logic                         ready;
   logic [CMD_WIDTH-1:0]         command;
   logic signed [SOCKET_ID_WIDTH:0] socket_id;
   logic [TIME_WIDTH-1:0]        now_ms;

   modport source (output valid, output command, output socket_id, output now_ms,
                   input ready);
   modport sink   (input valid, input command, input socket_id, input now_ms,
                   output ready);
endinterface

// ----- src/rdw_rsp_if.sv -----
interface rdw_rsp_if
   import rdw_pkg::*;
();
   logic                         valid;
   logic                         ready;
   logic                         breach;
   logic signed [TIME_WIDTH-1:0] elapsed_ms;
   logic                         guarded;

   modport source (output valid, output breach, output elapsed_ms, output guarded,
                   input ready);
   modport sink   (input valid, input breach, input elapsed_ms, input guarded,
                   output ready);
endinterface

// ----- src/rdw_record.sv -----
module rdw_record
   import rdw_pkg::*;
#(
   parameter int SOCKET_ID_WIDTH = SOCKET_ID_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          update,
   input  logic [CMD_WIDTH-1:0]          command,
   input  logic signed [SOCKET_ID_WIDTH:0] socket_id,
   input  logic [TIME_WIDTH-1:0]         now_ms,
   input  logic [TIME_WIDTH-1:0]         deadline_ms,
   output result_type                    result
);

   logic                       track_vld_ff, track_vld_in;
   logic [SOCKET_ID_WIDTH-1:0] track_id_ff, track_id_in;
   logic [TIME_WIDTH-1:0]      start_ff, start_in;
   logic                       started_ff, started_in;
   logic                       exempt_ff, exempt_in;
   logic                       breached_ff, breached_in;

   logic                  sock_ok;
   logic                  hit;
   logic [TIME_WIDTH-1:0] elapsed_raw;

   // sign bit set means no socket
   assign sock_ok     = ~socket_id[SOCKET_ID_WIDTH];
   assign hit         = sock_ok && track_vld_ff &&
                        (track_id_ff == socket_id[SOCKET_ID_WIDTH-1:0]);
   assign elapsed_raw = now_ms - start_ff;

   always_comb begin
      track_vld_in = track_vld_ff;
      track_id_in  = track_id_ff;
      start_in     = start_ff;
      started_in   = started_ff;
      exempt_in    = exempt_ff;
      breached_in  = breached_ff;
      result       = '0;
      unique case (cmd_type'(command))
         CMD_ARM: begin
            track_vld_in = sock_ok;
            track_id_in  = socket_id[SOCKET_ID_WIDTH-1:0];
            start_in     = '0;
            started_in   = 1'b0;
            exempt_in    = 1'b0;
            breached_in  = 1'b0;
         end
         CMD_EXEMPT: begin
            if (hit) begin
               exempt_in = 1'b1;
            end
         end
         CMD_DISARM: begin
            result.elapsed_ms = (track_vld_ff && started_ff && !breached_ff) ?
                                elapsed_raw : ELAPSED_NONE;
            track_vld_in = 1'b0;
            start_in     = '0;
            started_in   = 1'b0;
            exempt_in    = 1'b0;
            breached_in  = 1'b0;
         end
         CMD_CHECK: begin
            if (hit && !exempt_ff) begin
               priority if (breached_ff) begin
                  result.breach = 1'b1;
               end else if (!started_ff) begin
                  started_in = 1'b1;
                  start_in   = now_ms;
               end else if ((deadline_ms != '0) && (elapsed_raw >= deadline_ms)) begin
                  breached_in   = 1'b1;
                  result.breach = 1'b1;
               end else begin
                  // still inside the deadline: proceed
               end
            end
         end
         CMD_GUARD: begin
            result.guarded = hit && !exempt_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_vld_ff <= 1'b0;
         started_ff   <= 1'b0;
         exempt_ff    <= 1'b0;
         breached_ff  <= 1'b0;
         start_ff     <= '0;
      end else if (update) begin
         track_vld_ff <= track_vld_in;
         started_ff   <= started_in;
         exempt_ff    <= exempt_in;
         breached_ff  <= breached_in;
         start_ff     <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         track_id_ff <= track_id_in;
      end
   end

endmodule

// ----- src/response_deadline_watchdog.sv -----
// Response path: the result of an accepted request is held in the output register.
// Throughput: one request per cycle; the single output register is the only stage,
//   and a request is taken whenever that register is empty or being drained.
// Reset (synchronous, active high): clears the tracked record (nothing tracked,
//   clock not started, no exemption, no breach), sets deadline_ms to 0 and
//   empties the output register.
module response_deadline_watchdog
   import rdw_pkg::*;
#(
   parameter int SOCKET_ID_WIDTH = SOCKET_ID_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   rdw_req_if.sink                   req_chan,
   rdw_rsp_if.source                 rsp_chan,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   // ---------------------------------------------------------------
   // CSR: one register, deadline_ms, at byte address 0. Any address
   // whose word index is not the deadline is ignored on write and
   // reads back zero.
   // ---------------------------------------------------------------
   logic [TIME_WIDTH-1:0] deadline_ff;
   logic                  csr_wr;
   logic                  csr_idx;

   assign csr_idx    = csr_paddr[CSR_ADDR_WIDTH-1];
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_idx == CSR_IDX_DEADLINE);
   assign csr_prdata = (csr_idx == CSR_IDX_DEADLINE) ? deadline_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadline_ff <= '0;
      end else if (csr_wr) begin
         deadline_ff <= csr_pwdata;
      end
   end

   // ---------------------------------------------------------------
   // Handshake: take a request whenever the output register is free
   // or its current response leaves this cycle.
   // ---------------------------------------------------------------
   logic       rsp_vld_ff, rsp_vld_in;
   result_type rsp_data_ff;
   result_type result;
   logic       req_accept;

   assign req_chan.ready = !rsp_vld_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // record state and decision logic; state moves only on an accepted request
   rdw_record #(
      .SOCKET_ID_WIDTH (SOCKET_ID_WIDTH)
   ) u_record (
      .clock       (clock),
      .reset       (reset),
      .update      (req_accept),
      .command     (req_chan.command),
      .socket_id   (req_chan.socket_id),
      .now_ms      (req_chan.now_ms),
      .deadline_ms (deadline_ff),
      .result      (result)
   );

   assign rsp_vld_in = req_accept || (rsp_vld_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // response payload loads with each accepted request
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid      = rsp_vld_ff;
   assign rsp_chan.breach     = rsp_data_ff.breach;
   assign rsp_chan.elapsed_ms = rsp_data_ff.elapsed_ms;
   assign rsp_chan.guarded    = rsp_data_ff.guarded;

endmodule

// ----- src/rdw_checker.sv -----
module rdw_checker
   import rdw_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [CMD_WIDTH-1:0]         req_command,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_breach,
   input logic signed [TIME_WIDTH-1:0] rsp_elapsed_ms,
   input logic                         rsp_guarded
);

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // no new request while the output register is full and stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken over a stalled response");

   // only disarm reports an elapsed time
   a_elapsed_only_disarm: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command != CMD_DISARM)
      |=> rsp_valid && (rsp_elapsed_ms == '0))
      else $error("elapsed time on a non-disarm response");

   // unused command codes (above guard query) give an all-zero response
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command > CMD_GUARD)
      |=> rsp_valid && !rsp_breach && !rsp_guarded && (rsp_elapsed_ms == '0))
      else $error("nonzero response to an unused command");

   // breach and guarded come from different commands
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_breach && rsp_guarded))
      else $error("breach and guarded both set");

endmodule

bind response_deadline_watchdog rdw_checker u_rdw_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_command    (req_chan.command),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_breach     (rsp_chan.breach),
   .rsp_elapsed_ms (rsp_chan.elapsed_ms),
   .rsp_guarded    (rsp_chan.guarded)
);
